// ----- src/cvc_pkg.sv -----
// Shared types and constants for the spherical/Cartesian velocity converter.
// No dependencies; the top level, cvc_rotator and cvc_gain refer to this package by scoped names.
`default_nettype none

package cvc_pkg;

    // Command codes carried on the cmd port.
    localparam logic CMD_TO_SPH  = 1'b0;
    localparam logic CMD_TO_CART = 1'b1;

    // The CORDIC gain correction is 1/K as an unsigned Q30 value.
    localparam int          GAIN_FRAC  = 30;
    localparam logic [29:0] INV_GAIN   = 30'd652032874;

    // Headroom above the data width for CORDIC growth and negation.
    localparam int          GUARD_BITS = 4;

    // Per-word flags that ride along the whole pipeline.
    typedef struct packed {
        logic cmd;
        logic flip;
        logic phi_on;
        logic th_on;
        logic origin;
    } item_flags_t;

    // Control for one rotator section.
    typedef struct packed {
        logic vec;  // take directions from the sign of b and record them
        logic inv;  // reverse every direction
        logic en;   // rotate at all; otherwise pass the pair through
    } rot_ctl_t;

endpackage

`default_nettype wire

// ----- src/spherical_cartesian_velocity_convert.sv -----
// Throughput: one word per cycle while item_ready is high; the four CORDIC sections
// and three gain multipliers are fully pipelined, one micro-rotation per stage.
// Reset: rst_n clears every valid bit and the result buffer; no clearing pass is needed.
// item_ready is low only while the skid entry of the result buffer is occupied.
// Depends on cvc_pkg, cvc_rotator, cvc_gain and cvc_outbuf.
`default_nettype none

module spherical_cartesian_velocity_convert #(
    parameter int DATA_WIDTH     = 32,
    parameter int ROTATION_STEPS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic                          cmd,
    input  wire logic signed [DATA_WIDTH-1:0]  pos_x,
    input  wire logic signed [DATA_WIDTH-1:0]  pos_y,
    input  wire logic signed [DATA_WIDTH-1:0]  pos_z,
    input  wire logic signed [DATA_WIDTH-1:0]  vel_a,
    input  wire logic signed [DATA_WIDTH-1:0]  vel_b,
    input  wire logic signed [DATA_WIDTH-1:0]  vel_c,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic signed [DATA_WIDTH-1:0]       out_a,
    output logic signed [DATA_WIDTH-1:0]       out_b,
    output logic signed [DATA_WIDTH-1:0]       out_c,
    output logic                               at_origin,
    output logic                               saturated
);

    // Internal words carry a few guard bits so that CORDIC growth and negation of the
    // most negative input never wrap. Results are clipped back at the output buffer.
    localparam int W  = DATA_WIDTH;
    localparam int G  = cvc_pkg::GUARD_BITS;
    localparam int IW = DATA_WIDTH + cvc_pkg::GUARD_BITS;
    localparam int N  = ROTATION_STEPS;
    localparam int FW = $bits(cvc_pkg::item_flags_t);

    localparam int SA = FW + 4 * IW;        // azimuth vectoring sideband
    localparam int SB = SA + N;             // rho gain sideband
    localparam int SC = FW + 3 * IW + N;    // polar vectoring sideband
    localparam int SD = FW + IW + N;        // first velocity section sideband
    localparam int SF = FW + IW;            // second velocity section sideband

    // The whole pipeline moves together; it stops only when the result buffer is full.
    logic adv;

    // ------------------------------------------------------------------
    // Entry: sign-extend, classify the position, and set up the velocity
    // pair for the first velocity section. A position with negative x is
    // turned by 180 degrees first so the CORDIC sees the right half plane.
    // ------------------------------------------------------------------
    cvc_pkg::item_flags_t  e_flags;
    logic signed [IW-1:0]  xe, ye, ze, vae, vbe, vce;
    logic signed [IW-1:0]  e_px, e_py, e_nz, e_sa, e_sb;

    assign xe  = {{G{pos_x[W-1]}}, pos_x};
    assign ye  = {{G{pos_y[W-1]}}, pos_y};
    assign ze  = {{G{pos_z[W-1]}}, pos_z};
    assign vae = {{G{vel_a[W-1]}}, vel_a};
    assign vbe = {{G{vel_b[W-1]}}, vel_b};
    assign vce = {{G{vel_c[W-1]}}, vel_c};

    always_comb
    begin
        e_flags.cmd    = cmd;
        e_flags.flip   = pos_x[W-1];
        e_flags.phi_on = (|pos_x) | (|pos_y);
        e_flags.origin = ~e_flags.phi_on & ~(|pos_z);
        e_flags.th_on  = ~e_flags.origin;
        e_px = e_flags.flip ? -xe : xe;
        e_py = e_flags.flip ? -ye : ye;
        e_nz = -ze;
        // The forward path rotates the flipped horizontal velocity; the inverse
        // path starts from the radial and polar components as they are.
        if (cmd == cvc_pkg::CMD_TO_SPH && e_flags.flip)
        begin
            e_sa = -vae;
            e_sb = -vbe;
        end
        else
        begin
            e_sa = vae;
            e_sb = vbe;
        end
    end

    // ------------------------------------------------------------------
    // Section A: vectoring on (x, y) records the azimuth directions.
    // On the z axis the pair is zero, so rho is zero and the directions are unused.
    // ------------------------------------------------------------------
    logic                  a_valid;
    logic signed [IW-1:0]  a_x;
    logic [N-1:0]          a_dirs;
    logic [SA-1:0]         a_side;

    cvc_rotator #(.IW(IW), .STEPS(N), .SW(SA)) u_rot_azi (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (item_valid),
        .in_ctl   ('{vec: 1'b1, inv: 1'b0, en: 1'b1}),
        .in_a     (e_px),
        .in_b     (e_py),
        .in_dirs  ('0),
        .in_side  ({e_flags, e_nz, e_sa, e_sb, vce}),
        .out_valid(a_valid),
        .out_a    (a_x),
        .out_b    (),
        .out_dirs (a_dirs),
        .out_side (a_side)
    );

    // ------------------------------------------------------------------
    // Gain correction of the x result gives rho, the distance from the z axis.
    // ------------------------------------------------------------------
    logic                  b_valid;
    logic [0:0][IW-1:0]    b_rho;
    logic [SB-1:0]         b_side;

    cvc_gain #(.IW(IW), .LANES(1), .SW(SB)) u_gain_rho (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (a_valid),
        .in_en    (1'b1),
        .in_v     (a_x),
        .in_side  ({a_side, a_dirs}),
        .out_valid(b_valid),
        .out_v    (b_rho),
        .out_side (b_side)
    );

    cvc_pkg::item_flags_t  b_flags;
    logic signed [IW-1:0]  b_nz, b_sa, b_sb, b_sc;
    logic [N-1:0]          b_dphi;

    assign {b_flags, b_nz, b_sa, b_sb, b_sc, b_dphi} = b_side;

    // ------------------------------------------------------------------
    // Section C: vectoring on (rho, -z) records the polar directions.
    // ------------------------------------------------------------------
    logic                  c_valid;
    logic [N-1:0]          c_dth;
    logic [SC-1:0]         c_side;

    cvc_rotator #(.IW(IW), .STEPS(N), .SW(SC)) u_rot_pol (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (b_valid),
        .in_ctl   ('{vec: 1'b1, inv: 1'b0, en: 1'b1}),
        .in_a     (b_rho[0]),
        .in_b     (b_nz),
        .in_dirs  ('0),
        .in_side  ({b_flags, b_sa, b_sb, b_sc, b_dphi}),
        .out_valid(c_valid),
        .out_a    (),
        .out_b    (),
        .out_dirs (c_dth),
        .out_side (c_side)
    );

    cvc_pkg::item_flags_t  c_flags;
    logic signed [IW-1:0]  c_sa, c_sb, c_sc;
    logic [N-1:0]          c_dphi;
    logic [N-1:0]          c_dirs1;
    logic [N-1:0]          c_dirs2;
    logic                  c_to_cart;
    cvc_pkg::rot_ctl_t     c_ctl;

    assign {c_flags, c_sa, c_sb, c_sc, c_dphi} = c_side;

    // The forward path turns the velocity by the azimuth first and the polar
    // angle second; the inverse path undoes them in the opposite order.
    assign c_to_cart = (c_flags.cmd == cvc_pkg::CMD_TO_CART);
    assign c_dirs1   = c_to_cart ? c_dth  : c_dphi;
    assign c_dirs2   = c_to_cart ? c_dphi : c_dth;
    assign c_ctl     = '{vec: 1'b0, inv: c_to_cart,
                         en: c_to_cart ? c_flags.th_on : c_flags.phi_on};

    // ------------------------------------------------------------------
    // Section D and its gain: first velocity rotation.
    // ------------------------------------------------------------------
    logic                  d_valid;
    logic signed [IW-1:0]  d_a, d_b;
    logic [SD-1:0]         d_side;

    cvc_rotator #(.IW(IW), .STEPS(N), .SW(SD)) u_rot_v1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (c_valid),
        .in_ctl   (c_ctl),
        .in_a     (c_sa),
        .in_b     (c_sb),
        .in_dirs  (c_dirs1),
        .in_side  ({c_flags, c_sc, c_dirs2}),
        .out_valid(d_valid),
        .out_a    (d_a),
        .out_b    (d_b),
        .out_dirs (),
        .out_side (d_side)
    );

    cvc_pkg::item_flags_t  d_flags;
    logic                  d_en;

    assign d_flags = d_side[SD-1 -: FW];
    assign d_en    = (d_flags.cmd == cvc_pkg::CMD_TO_CART) ? d_flags.th_on : d_flags.phi_on;

    logic                  e1_valid;
    logic [1:0][IW-1:0]    e1_v;
    logic [SD-1:0]         e1_side;

    cvc_gain #(.IW(IW), .LANES(2), .SW(SD)) u_gain_v1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (d_valid),
        .in_en    (d_en),
        .in_v     ({d_a, d_b}),
        .in_side  (d_side),
        .out_valid(e1_valid),
        .out_v    (e1_v),
        .out_side (e1_side)
    );

    cvc_pkg::item_flags_t  m_flags;
    logic signed [IW-1:0]  m_p, m_q, m_c;
    logic [N-1:0]          m_dirs;
    logic signed [IW-1:0]  m_a2, m_b2, m_c2;
    logic                  m_to_cart;
    cvc_pkg::rot_ctl_t     m_ctl;

    assign {m_flags, m_c, m_dirs} = e1_side;
    assign m_p       = e1_v[1];
    assign m_q       = e1_v[0];
    assign m_to_cart = (m_flags.cmd == cvc_pkg::CMD_TO_CART);

    // Regroup between the two velocity rotations. Forward: the second pair is
    // (horizontal radial, -Vz) with the azimuthal part held aside. Inverse: the
    // second pair is (horizontal part, Vphi) with Vz held aside. When the polar
    // stage is skipped (origin), the components are only permuted.
    always_comb
    begin
        if (!m_to_cart)
        begin
            if (m_flags.th_on)
            begin
                m_a2 = m_p;
                m_b2 = -m_c;
            end
            else
            begin
                m_a2 = m_c;
                m_b2 = m_p;
            end
            m_c2 = m_q;
        end
        else
        begin
            if (m_flags.th_on)
            begin
                m_a2 = m_p;
                m_c2 = -m_q;
            end
            else
            begin
                m_a2 = m_q;
                m_c2 = m_p;
            end
            m_b2 = m_c;
        end
    end

    assign m_ctl = '{vec: 1'b0, inv: m_to_cart,
                     en: m_to_cart ? m_flags.phi_on : m_flags.th_on};

    // ------------------------------------------------------------------
    // Section F and its gain: second velocity rotation.
    // ------------------------------------------------------------------
    logic                  f_valid;
    logic signed [IW-1:0]  f_a, f_b;
    logic [SF-1:0]         f_side;

    cvc_rotator #(.IW(IW), .STEPS(N), .SW(SF)) u_rot_v2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (e1_valid),
        .in_ctl   (m_ctl),
        .in_a     (m_a2),
        .in_b     (m_b2),
        .in_dirs  (m_dirs),
        .in_side  ({m_flags, m_c2}),
        .out_valid(f_valid),
        .out_a    (f_a),
        .out_b    (f_b),
        .out_dirs (),
        .out_side (f_side)
    );

    cvc_pkg::item_flags_t  f_flags;
    logic                  f_en;

    assign f_flags = f_side[SF-1 -: FW];
    assign f_en    = (f_flags.cmd == cvc_pkg::CMD_TO_CART) ? f_flags.phi_on : f_flags.th_on;

    logic                  g_valid;
    logic [1:0][IW-1:0]    g_v;
    logic [SF-1:0]         g_side;

    cvc_gain #(.IW(IW), .LANES(2), .SW(SF)) u_gain_v2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (f_valid),
        .in_en    (f_en),
        .in_v     ({f_a, f_b}),
        .in_side  (f_side),
        .out_valid(g_valid),
        .out_v    (g_v),
        .out_side (g_side)
    );

    // ------------------------------------------------------------------
    // Final: the inverse path undoes the 180 degree turn last, then the
    // three components are clipped and buffered.
    // ------------------------------------------------------------------
    cvc_pkg::item_flags_t  g_flags;
    logic signed [IW-1:0]  g_c;
    logic signed [IW-1:0]  r1, r2;
    logic                  g_unflip;

    assign {g_flags, g_c} = g_side;
    assign g_unflip = (g_flags.cmd == cvc_pkg::CMD_TO_CART) & g_flags.flip;
    assign r1       = g_unflip ? -$signed(g_v[1]) : $signed(g_v[1]);
    assign r2       = g_unflip ? -$signed(g_v[0]) : $signed(g_v[0]);

    cvc_outbuf #(.W(W), .IW(IW)) u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_a      (r1),
        .in_b      (r2),
        .in_c      (g_c),
        .in_origin (g_flags.origin),
        .ready     (adv),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .out_origin(at_origin),
        .out_sat   (saturated)
    );

    assign item_ready = adv;

endmodule

`default_nettype wire

// ----- src/cvc_rotator.sv -----
// Pipelined CORDIC section: one micro-rotation per register stage.
// Depends on cvc_pkg for the rotator control struct.
`default_nettype none

module cvc_rotator #(
    parameter int IW    = 36,
    parameter int STEPS = 24,
    parameter int SW    = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic                    in_valid,
    input  wire cvc_pkg::rot_ctl_t       in_ctl,
    input  wire logic signed [IW-1:0]    in_a,
    input  wire logic signed [IW-1:0]    in_b,
    input  wire logic [STEPS-1:0]        in_dirs,
    input  wire logic [SW-1:0]           in_side,
    output logic                         out_valid,
    output logic signed [IW-1:0]         out_a,
    output logic signed [IW-1:0]         out_b,
    output logic [STEPS-1:0]             out_dirs,
    output logic [SW-1:0]                out_side
);

    logic [STEPS-1:0]      valid_reg;
    cvc_pkg::rot_ctl_t     ctl_reg   [STEPS];
    logic signed [IW-1:0]  a_reg     [STEPS];
    logic signed [IW-1:0]  b_reg     [STEPS];
    logic [STEPS-1:0]      dirs_reg  [STEPS];
    logic [SW-1:0]         side_reg  [STEPS];

    logic [STEPS-1:0]      valid_next;
    cvc_pkg::rot_ctl_t     ctl_next  [STEPS];
    logic signed [IW-1:0]  a_next    [STEPS];
    logic signed [IW-1:0]  b_next    [STEPS];
    logic [STEPS-1:0]      dirs_next [STEPS];
    logic [SW-1:0]         side_next [STEPS];

    // Each stage reads only the register of the stage before it.
    always_comb
    begin
        logic                  sv;
        cvc_pkg::rot_ctl_t     sc;
        logic signed [IW-1:0]  sa;
        logic signed [IW-1:0]  sb;
        logic [STEPS-1:0]      sd;
        logic [SW-1:0]         ss;
        logic signed [IW-1:0]  da;
        logic signed [IW-1:0]  db;
        logic                  plus;
        logic                  rot_plus;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                sv = in_valid;
                sc = in_ctl;
                sa = in_a;
                sb = in_b;
                sd = in_dirs;
                ss = in_side;
            end
            else
            begin
                sv = valid_reg[i-1];
                sc = ctl_reg[i-1];
                sa = a_reg[i-1];
                sb = b_reg[i-1];
                sd = dirs_reg[i-1];
                ss = side_reg[i-1];
            end
            da       = sb >>> i;
            db       = sa >>> i;
            plus     = sc.vec ? ~sb[IW-1] : sd[i];
            rot_plus = plus ^ sc.inv;

            valid_next[i]   = sv;
            ctl_next[i]     = sc;
            side_next[i]    = ss;
            dirs_next[i]    = sd;
            dirs_next[i][i] = plus;
            a_next[i]       = sa;
            b_next[i]       = sb;
            if (sc.en)
            begin
                if (rot_plus)
                begin
                    a_next[i] = sa + da;
                    b_next[i] = sb - db;
                end
                else
                begin
                    a_next[i] = sa - da;
                    b_next[i] = sb + db;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                ctl_reg[i]  <= ctl_next[i];
                a_reg[i]    <= a_next[i];
                b_reg[i]    <= b_next[i];
                dirs_reg[i] <= dirs_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_a     = a_reg[STEPS-1];
    assign out_b     = b_reg[STEPS-1];
    assign out_dirs  = dirs_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

`default_nettype wire

// ----- src/cvc_gain.sv -----
// Two-stage CORDIC gain correction: multiply by 1/K in Q30, round half away from zero.
// Depends on cvc_pkg for the gain constant.
`default_nettype none

module cvc_gain #(
    parameter int IW    = 36,
    parameter int LANES = 2,
    parameter int SW    = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire logic                        in_en,
    input  wire logic [LANES-1:0][IW-1:0]    in_v,
    input  wire logic [SW-1:0]               in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][IW-1:0]         out_v,
    output logic [SW-1:0]                    out_side
);

    localparam int GF   = cvc_pkg::GAIN_FRAC;
    localparam int LO_W = IW / 2;
    localparam int HI_W = IW - LO_W;
    localparam int SUMW = IW + GF + 1;

    // First stage: magnitude split into two halves, each multiplied by the constant.
    logic                              v1_reg;
    logic                              en1_reg;
    logic [SW-1:0]                     side1_reg;
    logic [LANES-1:0]                  neg1_reg;
    logic [LANES-1:0][IW-1:0]          raw1_reg;
    logic [LANES-1:0][LO_W+GF-1:0]     plo1_reg;
    logic [LANES-1:0][HI_W+GF-1:0]     phi1_reg;

    logic [LANES-1:0]                  neg1_next;
    logic [LANES-1:0][LO_W+GF-1:0]     plo1_next;
    logic [LANES-1:0][HI_W+GF-1:0]     phi1_next;

    // Second stage: sum, round and restore the sign, or pass the raw value when in_en is low.
    logic                              v2_reg;
    logic [SW-1:0]                     side2_reg;
    logic [LANES-1:0][IW-1:0]          res2_reg;
    logic [LANES-1:0][IW-1:0]          res2_next;

    always_comb
    begin
        logic [IW-1:0] mag;
        for (int l = 0; l < LANES; l++)
        begin
            neg1_next[l] = in_v[l][IW-1];
            mag          = in_v[l][IW-1] ? (~in_v[l] + 1'b1) : in_v[l];
            plo1_next[l] = {{GF{1'b0}}, mag[LO_W-1:0]} * {{LO_W{1'b0}}, cvc_pkg::INV_GAIN};
            phi1_next[l] = {{GF{1'b0}}, mag[IW-1:LO_W]} * {{HI_W{1'b0}}, cvc_pkg::INV_GAIN};
        end
    end

    always_comb
    begin
        logic [SUMW-1:0] sum;
        logic [IW-1:0]   r;
        for (int l = 0; l < LANES; l++)
        begin
            sum = {1'b0, phi1_reg[l], {LO_W{1'b0}}}
                + {{(HI_W+1){1'b0}}, plo1_reg[l]}
                + (SUMW'(1) << (GF - 1));
            r   = sum[GF +: IW];
            if (!en1_reg)
            begin
                res2_next[l] = raw1_reg[l];
            end
            else if (neg1_reg[l])
            begin
                res2_next[l] = ~r + 1'b1;
            end
            else
            begin
                res2_next[l] = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            en1_reg   <= in_en;
            side1_reg <= in_side;
            neg1_reg  <= neg1_next;
            raw1_reg  <= in_v;
            plo1_reg  <= plo1_next;
            phi1_reg  <= phi1_next;
            side2_reg <= side1_reg;
            res2_reg  <= res2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_v     = res2_reg;
    assign out_side  = side2_reg;

endmodule

`default_nettype wire

// ----- src/cvc_outbuf.sv -----
// Output clipping and two-entry result buffer (output register plus skid entry).
// No package dependency; widths come from the parameters.
`default_nettype none

module cvc_outbuf #(
    parameter int W  = 32,
    parameter int IW = 36
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [IW-1:0]         in_a,
    input  wire logic [IW-1:0]         in_b,
    input  wire logic [IW-1:0]         in_c,
    input  wire logic                  in_origin,
    output logic                       ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [W-1:0]        out_a,
    output logic signed [W-1:0]        out_b,
    output logic signed [W-1:0]        out_c,
    output logic                       out_origin,
    output logic                       out_sat
);

    localparam int PW = 3 * W + 2;

    // Returns {clipped, value}.
    function automatic logic [W:0] clip(input logic [IW-1:0] v);
        logic [W:0] r;
        logic       fits;
        fits = (&v[IW-1:W-1]) | ~(|v[IW-1:W-1]);
        if (fits)
        begin
            r = {1'b0, v[W-1:0]};
        end
        else
        begin
            r = {1'b1, v[IW-1], {(W-1){~v[IW-1]}}};
        end
        return r;
    endfunction

    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic [PW-1:0] out_reg;
    logic [PW-1:0] skid_reg;
    logic [PW-1:0] in_word;
    logic [W:0]    ca;
    logic [W:0]    cb;
    logic [W:0]    cc;
    logic          push;
    logic          take;

    assign ca      = clip(in_a);
    assign cb      = clip(in_b);
    assign cc      = clip(in_c);
    assign in_word = {in_origin, ca[W] | cb[W] | cc[W], ca[W-1:0], cb[W-1:0], cc[W-1:0]};

    assign ready = ~skid_valid_reg;
    assign push  = in_valid & ~skid_valid_reg;
    assign take  = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_reg <= in_word;
            end
            else
            begin
                skid_reg <= in_word;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_origin = out_reg[PW-1];
    assign out_sat    = out_reg[PW-2];
    assign out_a      = out_reg[3*W-1:2*W];
    assign out_b      = out_reg[2*W-1:W];
    assign out_c      = out_reg[W-1:0];

endmodule

`default_nettype wire

// ----- src/cvc_checker.sv -----
// Port-level checks for the velocity converter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cvc_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   item_valid,
    input wire logic                   item_ready,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire logic [DATA_WIDTH-1:0]  out_a,
    input wire logic [DATA_WIDTH-1:0]  out_b,
    input wire logic [DATA_WIDTH-1:0]  out_c,
    input wire logic                   at_origin,
    input wire logic                   saturated
);

    // A word waiting on the output stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(out_a) && $stable(out_b) && $stable(out_c))
        else $error("result word changed while stalled");

    // The input stalls only when the buffer holds a word that is not yet taken.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with an empty output");

    // At the origin the result is a permutation of the input, so it never clips.
    a_origin_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && at_origin |-> !saturated)
        else $error("origin result flagged as saturated");

endmodule

bind spherical_cartesian_velocity_convert cvc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cvc_checker (.*);

`default_nettype wire
